/* rtl/cfn_pkg.sv */
package cfn_pkg;

    localparam int DIVIDEND_W  = 17;
    localparam int REM_W       = 9;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W      = 37;
    localparam int DAY_W       = 18;
    localparam int YEAR_W      = 15;
    localparam int MLEN_W      = 5;

    localparam logic [REM_W-1:0]      DIV_60        = 9'd60;
    localparam logic [REM_W-1:0]      DIV_24        = 9'd24;
    localparam logic [REM_W-1:0]      DIV_400       = 9'd400;
    localparam logic [RECIP_W-1:0]    RECIP_60      = 20'd279620;
    localparam logic [RECIP_W-1:0]    RECIP_24      = 20'd699050;
    localparam logic [RECIP_W-1:0]    RECIP_400     = 20'd41943;
    localparam logic [REM_W-1:0]      Y400_LAST     = 9'd399;
    localparam logic [DIVIDEND_W-1:0] YEAR_BASE     = 17'd1900;
    localparam logic [3:0]            MONTH_FIRST   = 4'd0;
    localparam logic [3:0]            MONTH_LAST    = 4'd11;
    localparam logic [3:0]            MONTH_COUNT   = 4'd12;
    localparam logic [3:0]            MONTH_FEB     = 4'd1;
    localparam logic [12:0]           YEAR_OUT_MAX  = 13'd8191;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEC,
        ST_MIN,
        ST_HOUR,
        ST_YEAR,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [REM_W-1:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quot;
        logic [REM_W-1:0]      rem;
    } div_rsp_t;

    // y400 is the full year modulo 400
    function automatic logic is_leap(input logic [REM_W-1:0] y400);
        return (y400[1:0] == 2'b00) && (y400 != 9'd100) && (y400 != 9'd200)
            && (y400 != 9'd300);
    endfunction

    function automatic logic [MLEN_W-1:0] month_days(input logic [3:0] month,
                                                     input logic leap);
        logic [MLEN_W-1:0] d;
        case (month) inside
            MONTH_FEB:                   d = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:     d = 5'd30;
            default:                     d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

/* rtl/cfn_divider.sv */
module cfn_divider (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfn_pkg::div_req_t req,
    output cfn_pkg::div_rsp_t rsp
);
    import cfn_pkg::*;

    logic [DIVIDEND_W-1:0] num_reg, num_next;
    logic [REM_W-1:0]      div_reg, div_next;
    logic [RECIP_W-1:0]    recip_reg, recip_next;
    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [REM_W:0]        part_reg, part_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic                  est_reg, est_next;
    logic                  back_reg, back_next;
    logic                  fix_reg, fix_next;
    logic                  done_reg, done_next;

    logic [RECIP_W-1:0]    recip_sel;
    logic [DIVIDEND_W-1:0] mul_a;
    logic [RECIP_W-1:0]    mul_b;
    logic [PROD_W-1:0]     prod;
    logic [DIVIDEND_W-1:0] back_diff;
    logic [REM_W:0]        part_sub;
    logic                  part_over;

    always_comb begin
        case (req.divisor)
            DIV_60:  recip_sel = RECIP_60;
            DIV_24:  recip_sel = RECIP_24;
            default: recip_sel = RECIP_400;
        endcase
    end

    // shared multiplier: reciprocal estimate first, then estimate times divisor
    assign mul_a     = est_reg ? num_reg : quot_reg;
    assign mul_b     = est_reg ? recip_reg : {{(RECIP_W-REM_W){1'b0}}, div_reg};
    assign prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign back_diff = num_reg - prod[DIVIDEND_W-1:0];
    assign part_sub  = part_reg - {1'b0, div_reg};
    assign part_over = part_reg >= {1'b0, div_reg};

    always_comb begin
        num_next   = num_reg;
        div_next   = div_reg;
        recip_next = recip_reg;
        quot_next  = quot_reg;
        part_next  = part_reg;
        rem_next   = rem_reg;
        est_next   = req.start;
        back_next  = est_reg;
        fix_next   = back_reg;
        done_next  = fix_reg;
        if (req.start) begin
            num_next   = req.dividend;
            div_next   = req.divisor;
            recip_next = recip_sel;
        end
        if (est_reg) begin
            quot_next = {{(DIVIDEND_W-PROD_W+RECIP_SHIFT){1'b0}},
                         prod[PROD_W-1:RECIP_SHIFT]};
        end
        if (back_reg) begin
            part_next = back_diff[REM_W:0];
        end
        if (fix_reg) begin
            if (part_over) begin
                quot_next = quot_reg + 1'b1;
                rem_next  = part_sub[REM_W-1:0];
            end else begin
                rem_next  = part_reg[REM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_reg  <= 1'b0;
            back_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            est_reg  <= est_next;
            back_reg <= back_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
        end
        num_reg   <= num_next;
        div_reg   <= div_next;
        recip_reg <= recip_next;
        quot_reg  <= quot_next;
        part_reg  <= part_next;
        rem_reg   <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

/* rtl/calendar_field_normalizer_unit.sv */
// Normalizes one broken-down Gregorian date and time per request. Seconds carry
// into minutes, minutes into hours and hours into days through one shared
// divider (divide by 60, 60, 24, then the year by 400 for the leap test). Each
// division multiplies by a fixed reciprocal, multiplies the estimate back on
// the same multiplier and corrects it with one compare and subtract; the day is
// then walked one month per cycle until it lies inside its month. The result is
// loaded once the four divisions and the walk are done, where the walk crosses
// up to about 1170 months for the widest day field, and a new request can be
// taken in the cycle after the result is loaded. The finished result sits in an
// output register, so the next request can start while it waits to be taken; a
// walk that ends while the result before it is still waiting holds until that
// one is taken. A year below 0 or above 8191 saturates and raises range_error.
module calendar_field_normalizer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // second_in[15:0], minute_in[31:16], hour_in[47:32], day_in[63:48],
    // month_in[67:64], year_in[80:68], zero fill up to 88 bits
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // second_out[5:0], minute_out[11:6], hour_out[16:12], day_out[21:17],
    // month_out[25:22], year_out[38:26], range_error[39]
    output logic [39:0] m_tdata
);
    import cfn_pkg::*;

    state_t state_reg, state_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [15:0]              min_reg, min_next;
    logic [15:0]              hour_reg, hour_next;
    logic signed [DAY_W-1:0]  day_reg, day_next;
    logic [3:0]               month_reg, month_next;
    logic signed [YEAR_W-1:0] year_reg, year_next;
    logic [REM_W-1:0]         y400_reg, y400_next;
    logic [5:0]               sec_out_reg, sec_out_next;
    logic [5:0]               min_out_reg, min_out_next;
    logic [4:0]               hour_out_reg, hour_out_next;
    logic [39:0]              m_tdata_reg, m_tdata_next;
    logic                     m_tvalid_reg, m_tvalid_next;

    logic                     s_accept;
    logic [3:0]               month_in;
    logic [MLEN_W-1:0]        len_cur;
    logic [MLEN_W-1:0]        len_prev;
    logic signed [DAY_W-1:0]  len_cur_s;
    logic signed [DAY_W-1:0]  len_prev_s;
    logic [3:0]               month_prev;
    logic [3:0]               month_fwd;
    logic [REM_W-1:0]         y400_prev;
    logic [REM_W-1:0]         y400_fwd;
    logic                     day_nonpos;
    logic                     day_over;
    logic                     walk_done;
    logic                     out_free;
    logic [12:0]              year_sat;
    logic                     range_err;

    cfn_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_accept = s_tvalid && s_tready;
    assign month_in = s_tdata[67:64];
    assign out_free = !m_tvalid_reg || m_tready;

    // month walk arithmetic
    assign month_prev = (month_reg == MONTH_FIRST) ? MONTH_LAST : month_reg - 1'b1;
    assign month_fwd  = (month_reg == MONTH_LAST) ? MONTH_FIRST : month_reg + 1'b1;
    assign y400_prev  = (month_reg != MONTH_FIRST) ? y400_reg
                      : ((y400_reg == '0) ? Y400_LAST : y400_reg - 1'b1);
    assign y400_fwd   = (month_reg != MONTH_LAST) ? y400_reg
                      : ((y400_reg == Y400_LAST) ? '0 : y400_reg + 1'b1);
    assign len_cur    = month_days(month_reg, is_leap(y400_reg));
    assign len_prev   = month_days(month_prev, is_leap(y400_prev));
    assign len_cur_s  = signed'({{(DAY_W-MLEN_W){1'b0}}, len_cur});
    assign len_prev_s = signed'({{(DAY_W-MLEN_W){1'b0}}, len_prev});
    assign day_nonpos = day_reg[DAY_W-1] || (day_reg == '0);
    assign day_over   = day_reg > len_cur_s;
    assign walk_done  = !day_nonpos && !day_over;

    // year saturation
    always_comb begin
        if (year_reg[YEAR_W-1]) begin
            year_sat  = '0;
            range_err = 1'b1;
        end else if (year_reg > signed'({2'b00, YEAR_OUT_MAX})) begin
            year_sat  = YEAR_OUT_MAX;
            range_err = 1'b1;
        end else begin
            year_sat  = year_reg[12:0];
            range_err = 1'b0;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_SEC;
            ST_SEC:  if (div_rsp.done) state_next = ST_MIN;
            ST_MIN:  if (div_rsp.done) state_next = ST_HOUR;
            ST_HOUR: if (div_rsp.done) state_next = ST_YEAR;
            ST_YEAR: if (div_rsp.done) state_next = ST_WALK;
            ST_WALK: if (walk_done && out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // divider requests
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = DIV_60;
        unique case (state_reg)
            ST_IDLE: begin
                div_req.start    = s_accept;
                div_req.dividend = {1'b0, s_tdata[15:0]};
                div_req.divisor  = DIV_60;
            end
            ST_SEC: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = {1'b0, min_reg} + div_rsp.quot;
                div_req.divisor  = DIV_60;
            end
            ST_MIN: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = {1'b0, hour_reg} + div_rsp.quot;
                div_req.divisor  = DIV_24;
            end
            ST_HOUR: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = {2'b00, year_reg} + YEAR_BASE;
                div_req.divisor  = DIV_400;
            end
            ST_YEAR, ST_WALK: begin
                div_req.start = 1'b0;
            end
            default: div_req.start = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        min_next      = min_reg;
        hour_next     = hour_reg;
        day_next      = day_reg;
        month_next    = month_reg;
        year_next     = year_reg;
        y400_next     = y400_reg;
        sec_out_next  = sec_out_reg;
        min_out_next  = min_out_reg;
        hour_out_next = hour_out_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    min_next  = s_tdata[31:16];
                    hour_next = s_tdata[47:32];
                    day_next  = DAY_W'(signed'(s_tdata[63:48]));
                    year_next = signed'({2'b00, s_tdata[80:68]});
                    if (month_in >= MONTH_COUNT) begin
                        month_next = month_in - MONTH_COUNT;
                        year_next  = signed'({2'b00, s_tdata[80:68]}) + 15'sd1;
                    end else begin
                        month_next = month_in;
                    end
                end
            end
            ST_SEC:  if (div_rsp.done) sec_out_next = div_rsp.rem[5:0];
            ST_MIN:  if (div_rsp.done) min_out_next = div_rsp.rem[5:0];
            ST_HOUR: begin
                if (div_rsp.done) begin
                    hour_out_next = div_rsp.rem[4:0];
                    day_next      = day_reg + signed'({1'b0, div_rsp.quot});
                end
            end
            ST_YEAR: if (div_rsp.done) y400_next = div_rsp.rem;
            ST_WALK: begin
                if (day_nonpos) begin
                    day_next   = day_reg + len_prev_s;
                    month_next = month_prev;
                    y400_next  = y400_prev;
                    if (month_reg == MONTH_FIRST) year_next = year_reg - 15'sd1;
                end else if (day_over) begin
                    day_next   = day_reg - len_cur_s;
                    month_next = month_fwd;
                    y400_next  = y400_fwd;
                    if (month_reg == MONTH_LAST) year_next = year_reg + 15'sd1;
                end else if (out_free) begin
                    m_tdata_next  = {range_err, year_sat, month_reg, day_reg[4:0],
                                     hour_out_reg, min_out_reg, sec_out_reg};
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                m_tvalid_next = m_tvalid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        min_reg      <= min_next;
        hour_reg     <= hour_next;
        day_reg      <= day_next;
        month_reg    <= month_next;
        year_reg     <= year_next;
        y400_reg     <= y400_next;
        sec_out_reg  <= sec_out_next;
        min_out_reg  <= min_out_next;
        hour_out_reg <= hour_out_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int RANDOM_ITEMS = 1950;
    localparam int CYCLE_LIMIT  = 10_000_000;

    // laid out like m_tdata, lowest field last
    typedef struct packed {
        logic        err;
        logic [12:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } date_t;

    typedef struct {
        int    sec;
        int    mnt;
        int    hr;
        int    dy;
        int    mon;
        int    yr;
        bit    known;
        date_t want;
    } plan_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // second_in, minute_in, hour_in, day_in, month_in, year_in, zero fill
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // second_out, minute_out, hour_out, day_out, month_out, year_out, range_error
    logic [39:0] m_tdata;

    date_t     pending_dates[$];
    plan_row_t plan[$];
    int        error_count;
    int        cycle_count;
    bit        no_idle;

    calendar_field_normalizer_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** calendar_field_normalizer_unit: FAILED **");
            $finish;
        end
    end

    function automatic bit gregorian_leap(input int full_year);
        return (full_year % 4 == 0) && ((full_year % 100 != 0) || (full_year % 400 == 0));
    endfunction

    function automatic int month_length(input int yr, input int mon);
        int len;
        case (mon)
            1:             len = gregorian_leap(yr + 1900) ? 29 : 28;
            3, 5, 8, 10:   len = 30;
            default:       len = 31;
        endcase
        return len;
    endfunction

    function automatic date_t normalize_date(input logic [15:0] s_in, input logic [15:0] m_in,
                                             input logic [15:0] h_in, input logic [15:0] d_in,
                                             input logic [3:0] mo_in, input logic [12:0] y_in);
        int    sec;
        int    mnt;
        int    hr;
        int    dy;
        int    mon;
        int    yr;
        int    len;
        date_t r;
        sec = int'(s_in);
        mnt = int'(m_in);
        hr  = int'(h_in);
        mnt = mnt + sec / 60;
        sec = sec % 60;
        hr  = hr + mnt / 60;
        mnt = mnt % 60;
        dy  = int'($signed(d_in)) + hr / 24;
        hr  = hr % 24;
        mon = int'(mo_in);
        yr  = int'(y_in);
        if (mon >= 12) begin
            mon = mon - 12;
            yr  = yr + 1;
        end
        if (dy > 0) begin
            len = month_length(yr, mon);
            while (dy > len) begin
                dy  = dy - len;
                mon = mon + 1;
                if (mon == 12) begin
                    mon = 0;
                    yr  = yr + 1;
                end
                len = month_length(yr, mon);
            end
        end else begin
            while (dy <= 0) begin
                if (mon == 0) begin
                    mon = 11;
                    yr  = yr - 1;
                end else begin
                    mon = mon - 1;
                end
                dy = dy + month_length(yr, mon);
            end
        end
        r.err = 1'b0;
        if (yr < 0) begin
            yr    = 0;
            r.err = 1'b1;
        end else if (yr > 8191) begin
            yr    = 8191;
            r.err = 1'b1;
        end
        r.second = sec[5:0];
        r.minute = mnt[5:0];
        r.hour   = hr[4:0];
        r.day    = dy[4:0];
        r.month  = mon[3:0];
        r.year   = yr[12:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    task automatic compare_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 23);
    end

    always @(posedge aclk) begin
        date_t got;
        date_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_dates.size() == 0) begin
                report_mismatch("unexpected result", int'(m_tdata), 0);
            end else begin
                want = pending_dates.pop_front();
                compare_field("second", int'(got.second), int'(want.second));
                compare_field("minute", int'(got.minute), int'(want.minute));
                compare_field("hour", int'(got.hour), int'(want.hour));
                compare_field("day", int'(got.day), int'(want.day));
                compare_field("month", int'(got.month), int'(want.month));
                compare_field("year", int'(got.year), int'(want.year));
                compare_field("range_error", int'(got.err), int'(want.err));
            end
        end
    end

    task automatic add_row(input int s, input int m, input int h, input int d, input int mo,
                           input int y, input bit known, input date_t want);
        plan_row_t row;
        row.sec   = s;
        row.mnt   = m;
        row.hr    = h;
        row.dy    = d;
        row.mon   = mo;
        row.yr    = y;
        row.known = known;
        row.want  = want;
        plan.push_back(row);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_request(input int s, input int m, input int h, input int d, input int mo,
                                input int y, input bit known, input date_t want);
        logic [15:0] sec_f;
        logic [15:0] min_f;
        logic [15:0] hour_f;
        logic [15:0] day_f;
        logic [3:0]  mon_f;
        logic [12:0] year_f;
        sec_f  = 16'(s);
        min_f  = 16'(m);
        hour_f = 16'(h);
        day_f  = 16'(d);
        mon_f  = 4'(mo);
        year_f = 13'(y);
        pending_dates.push_back(known ? want
                                      : normalize_date(sec_f, min_f, hour_f, day_f, mon_f, year_f));
        while (!no_idle && $urandom_range(0, 99) < 23) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, year_f, mon_f, day_f, hour_f, min_f, sec_f};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_dates.size() != 0)
            @(negedge aclk);
    endtask

    task automatic send_random;
        int pick;
        int s;
        int m;
        int h;
        int d;
        int mo;
        int y;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            s  = $urandom_range(0, 200);
            m  = $urandom_range(0, 200);
            h  = $urandom_range(0, 100);
            d  = int'($urandom_range(0, 460)) - 60;
            mo = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 11);
            y  = $urandom_range(0, 8191);
        end else if (pick < 75) begin
            s  = $urandom_range(0, 119);
            m  = $urandom_range(0, 119);
            h  = $urandom_range(0, 47);
            d  = int'($urandom_range(0, 1600)) - 800;
            mo = $urandom_range(0, 15);
            y  = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(8188, 8191);
        end else if (pick < 88) begin
            s  = $urandom_range(0, 65535);
            m  = $urandom_range(0, 65535);
            h  = $urandom_range(0, 65535);
            d  = int'($urandom_range(0, 800)) - 400;
            mo = $urandom_range(0, 15);
            y  = $urandom_range(0, 8191);
        end else begin
            s  = $urandom_range(0, 65535);
            m  = $urandom_range(0, 65535);
            h  = $urandom_range(0, 65535);
            d  = $urandom_range(0, 65535);
            mo = $urandom_range(0, 15);
            y  = $urandom_range(0, 8191);
        end
        send_request(s, m, h, d, mo, y, 1'b0, '0);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        error_count = 0;
        cycle_count = 0;
        no_idle     = 1'b0;

        // extremes, carries, leap years, month wrap and year saturation
        add_row(0, 0, 0, 0, 0, 0, 1'b1, '{err: 1, year: 0, month: 11, day: 31,
                                          hour: 0, minute: 0, second: 0});
        add_row(0, 0, 0, 1, 0, 0, 1'b1, '{err: 0, year: 0, month: 0, day: 1,
                                          hour: 0, minute: 0, second: 0});
        add_row(59, 59, 23, 31, 11, 8191, 1'b1, '{err: 0, year: 8191, month: 11, day: 31,
                                                  hour: 23, minute: 59, second: 59});
        add_row(0, 0, 0, 32, 11, 8191, 1'b1, '{err: 1, year: 8191, month: 0, day: 1,
                                               hour: 0, minute: 0, second: 0});
        add_row(0, 0, 0, 1, 12, 8191, 1'b1, '{err: 1, year: 8191, month: 0, day: 1,
                                              hour: 0, minute: 0, second: 0});
        add_row(60, 0, 0, 1, 0, 10, 1'b1, '{err: 0, year: 10, month: 0, day: 1,
                                            hour: 0, minute: 1, second: 0});
        add_row(0, 60, 0, 1, 0, 10, 1'b1, '{err: 0, year: 10, month: 0, day: 1,
                                            hour: 1, minute: 0, second: 0});
        add_row(0, 0, 24, 31, 11, 50, 1'b1, '{err: 0, year: 51, month: 0, day: 1,
                                              hour: 0, minute: 0, second: 0});
        add_row(0, 0, 0, -1, 0, 1, 1'b1, '{err: 0, year: 0, month: 11, day: 30,
                                           hour: 0, minute: 0, second: 0});
        add_row(0, 0, 0, 29, 1, 100, 1'b1, '{err: 0, year: 100, month: 1, day: 29,
                                             hour: 0, minute: 0, second: 0});
        add_row(0, 0, 0, 29, 1, 0, 1'b1, '{err: 0, year: 0, month: 2, day: 1,
                                           hour: 0, minute: 0, second: 0});
        add_row(0, 0, 0, 29, 1, 104, 1'b1, '{err: 0, year: 104, month: 1, day: 29,
                                             hour: 0, minute: 0, second: 0});
        add_row(0, 0, 0, 29, 1, 101, 1'b1, '{err: 0, year: 101, month: 2, day: 1,
                                             hour: 0, minute: 0, second: 0});
        add_row(0, 0, 0, 0, 2, 100, 1'b1, '{err: 0, year: 100, month: 1, day: 29,
                                            hour: 0, minute: 0, second: 0});
        add_row(0, 0, 0, 31, 13, 5, 1'b1, '{err: 0, year: 6, month: 2, day: 3,
                                            hour: 0, minute: 0, second: 0});
        add_row(0, 0, 0, 0, 14, 8190, 1'b0, '0);
        add_row(30, 30, 12, 400, 15, 8190, 1'b0, '0);
        add_row(65535, 65535, 65535, 32767, 15, 8191, 1'b0, '0);
        add_row(65535, 65535, 65535, -32768, 0, 0, 1'b0, '0);
        add_row(0, 0, 0, -32768, 0, 0, 1'b0, '0);
        add_row(0, 0, 0, -32768, 11, 8191, 1'b0, '0);
        add_row(0, 0, 0, 32767, 0, 0, 1'b0, '0);
        add_row(0, 0, 0, 32767, 0, 8000, 1'b0, '0);
        add_row(12345, 54321, 999, -1000, 7, 4096, 1'b0, '0);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i])
            send_request(plan[i].sec, plan[i].mnt, plan[i].hr, plan[i].dy, plan[i].mon,
                         plan[i].yr, plan[i].known, plan[i].want);

        // hold off until the block has emptied
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 700) && (n < 1000);
            if (n == 1300)
                drain();
            send_random();
        end
        no_idle = 1'b0;

        drain();
        repeat (1500) @(negedge aclk);

        if (error_count == 0 && pending_dates.size() == 0) begin
            $display("** calendar_field_normalizer_unit: PASSED **");
        end else begin
            $display("** calendar_field_normalizer_unit: FAILED **");
        end
        $finish;
    end

endmodule
